/* hdl/tbsa_pkg.sv */
// Shared types, constants and helpers for the tiered bitmap slab allocator.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package tbsa_pkg;

  localparam int unsigned NUM_TIERS = 4;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned TIER_W    = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 8;

  // Slots per pool
  localparam int unsigned SLOTS_TINY   = 16;
  localparam int unsigned SLOTS_SMALL  = 16;
  localparam int unsigned SLOTS_MEDIUM = 16;
  localparam int unsigned SLOTS_LARGE  = 16;

  function automatic int unsigned clamp_slots(int unsigned n);
    if (n < 1) return 1;
    if (n > 32) return 32;
    return n;
  endfunction

  localparam int unsigned TIER_SLOTS [NUM_TIERS] = '{
    clamp_slots(SLOTS_TINY), clamp_slots(SLOTS_SMALL),
    clamp_slots(SLOTS_MEDIUM), clamp_slots(SLOTS_LARGE)
  };

  function automatic int unsigned max_slots();
    int unsigned m;
    m = 1;
    for (int t = 0; t < NUM_TIERS; t++) begin
      if (TIER_SLOTS[t] > m) m = TIER_SLOTS[t];
    end
    return m;
  endfunction

  localparam int unsigned MAX_SLOTS = max_slots();
  localparam int unsigned IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // log2 of slot size: 32, 128, 512, 2048 bytes
  localparam int unsigned TIER_SHIFT [NUM_TIERS] = '{5, 7, 9, 11};

  localparam logic [SIZE_W-1:0] SIZE_TINY   = 16'd32;
  localparam logic [SIZE_W-1:0] SIZE_SMALL  = 16'd128;
  localparam logic [SIZE_W-1:0] SIZE_MEDIUM = 16'd512;
  localparam logic [SIZE_W-1:0] SIZE_LARGE  = 16'd2048;

  localparam logic [ADDR_W-1:0] BASE_RESET [NUM_TIERS] = '{
    32'd0, 32'd4096, 32'd8192, 32'd16384
  };

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_NOT_SLOT  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_TINY   = 8'd0,
    REG_BASE_SMALL  = 8'd1,
    REG_BASE_MEDIUM = 8'd2,
    REG_BASE_LARGE  = 8'd3
  } reg_e;

  typedef logic [TIER_W-1:0]                    tier_t;
  typedef logic [MAX_SLOTS-1:0]                 map_t;
  typedef logic [NUM_TIERS-1:0][MAX_SLOTS-1:0]  maps_t;
  typedef logic [NUM_TIERS-1:0][ADDR_W-1:0]     bases_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] address;
    tier_t             tier;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

  // Bits of a pool bitmap that correspond to real slots
  function automatic map_t tier_mask(int unsigned t);
    map_t m;
    for (int i = 0; i < MAX_SLOTS; i++) m[i] = (i < TIER_SLOTS[t]);
    return m;
  endfunction

  // Low four bits of a slot index
  function automatic logic [SLOT_W-1:0] slot4(logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

/* hdl/tbsa_if.sv */
// Valid/ready channel interfaces: request, response and register write.
// Depends on tbsa_pkg for payload types.
`timescale 1ns / 1ps

interface tbsa_req_if;
  logic                             valid;
  logic                             ready;
  tbsa_pkg::cmd_e                   cmd;
  logic [tbsa_pkg::SIZE_W-1:0]      alloc_size;
  logic [tbsa_pkg::ADDR_W-1:0]      free_address;
  modport source(output valid, cmd, alloc_size, free_address, input ready);
  modport sink(input valid, cmd, alloc_size, free_address, output ready);
endinterface

interface tbsa_rsp_if;
  logic                             valid;
  logic                             ready;
  tbsa_pkg::status_e                status;
  logic [tbsa_pkg::ADDR_W-1:0]      address;
  tbsa_pkg::tier_t                  tier;
  logic [tbsa_pkg::SLOT_W-1:0]      slot_index;
  modport source(output valid, status, address, tier, slot_index, input ready);
  modport sink(input valid, status, address, tier, slot_index, output ready);
endinterface

interface tbsa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tbsa_pkg::CFG_IDX_W-1:0]   index;
  logic [tbsa_pkg::ADDR_W-1:0]      data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hdl/tbsa_core.sv */
// Combinational allocate/free decision for one request against the bitmaps.
// Depends on tbsa_pkg.
`timescale 1ns / 1ps

module tbsa_core (
  input  tbsa_pkg::req_t   req_i,
  input  tbsa_pkg::bases_t bases_i,
  input  tbsa_pkg::maps_t  maps_i,
  output tbsa_pkg::rsp_t   rsp_o,
  output tbsa_pkg::maps_t  maps_o
);
  import tbsa_pkg::*;

  logic [NUM_TIERS-1:0] found;
  logic [IDX_W-1:0]     idx_a [NUM_TIERS];
  logic [NUM_TIERS-1:0] in_rng;
  logic [NUM_TIERS-1:0] aligned;
  logic [IDX_W-1:0]     idx_f [NUM_TIERS];

  tier_t fit_tier;
  logic  bad_size;
  tier_t sel_a;
  logic  hit_a;
  tier_t sel_f;
  logic  hit_f;

  // Lowest free slot in every pool
  always_comb begin
    map_t open_bits;
    for (int t = 0; t < NUM_TIERS; t++) begin
      open_bits = ~maps_i[t] & tier_mask(t);
      found[t]  = |open_bits;
      idx_a[t]  = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
        if (open_bits[i]) idx_a[t] = IDX_W'(i);
      end
    end
  end

  // Range and alignment of the free address against every pool
  always_comb begin
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] shifted;
    for (int t = 0; t < NUM_TIERS; t++) begin
      off        = req_i.free_address - bases_i[t];
      shifted    = off >> TIER_SHIFT[t];
      in_rng[t]  = (req_i.free_address >= bases_i[t]) &&
                   (off < ADDR_W'(TIER_SLOTS[t] << TIER_SHIFT[t]));
      aligned[t] = (off & ((32'd1 << TIER_SHIFT[t]) - 32'd1)) == '0;
      idx_f[t]   = shifted[IDX_W-1:0];
    end
  end

  always_comb begin
    bad_size = (req_i.alloc_size == '0) || (req_i.alloc_size > SIZE_LARGE);
    if (req_i.alloc_size > SIZE_MEDIUM)     fit_tier = 2'd3;
    else if (req_i.alloc_size > SIZE_SMALL) fit_tier = 2'd2;
    else if (req_i.alloc_size > SIZE_TINY)  fit_tier = 2'd1;
    else                                    fit_tier = 2'd0;

    // fall back upward from the fitting tier
    sel_a = '0;
    hit_a = 1'b0;
    for (int t = NUM_TIERS - 1; t >= 0; t--) begin
      if (found[t] && (TIER_W'(t) >= fit_tier)) begin
        sel_a = TIER_W'(t);
        hit_a = 1'b1;
      end
    end

    // first pool holding the address wins, even if it is off a boundary
    sel_f = '0;
    hit_f = 1'b0;
    for (int t = NUM_TIERS - 1; t >= 0; t--) begin
      if (in_rng[t]) begin
        sel_f = TIER_W'(t);
        hit_f = 1'b1;
      end
    end
  end

  always_comb begin
    rsp_o  = '{status: ST_FULL, address: '0, tier: '0, slot_index: '0};
    maps_o = maps_i;
    if (req_i.cmd == CMD_ALLOC) begin
      if (bad_size) begin
        rsp_o.status = ST_BAD_SIZE;
      end else if (hit_a) begin
        rsp_o.status     = ST_ALLOCATED;
        rsp_o.address    = bases_i[sel_a] + (ADDR_W'(idx_a[sel_a]) << TIER_SHIFT[sel_a]);
        rsp_o.tier       = sel_a;
        rsp_o.slot_index = slot4(idx_a[sel_a]);
        maps_o[sel_a][idx_a[sel_a]] = 1'b1;
      end
    end else begin
      rsp_o.status = ST_NOT_SLOT;
      if (hit_f && aligned[sel_f]) begin
        rsp_o.status     = ST_FREED;
        rsp_o.tier       = sel_f;
        rsp_o.slot_index = slot4(idx_f[sel_f]);
        maps_o[sel_f][idx_f[sel_f]] = 1'b0;
      end
    end
  end

endmodule

/* hdl/tiered_bitmap_slab_allocator_unit.sv */
// Top level of the tiered bitmap slab allocator: channel handshake,
// base registers, pool bitmaps. Depends on tbsa_pkg, tbsa_if, tbsa_core.
`timescale 1ns / 1ps

// Four pools of 32/128/512/2048-byte slots, one used bitmap each. Every
// request item yields exactly one response item. One item is accepted per
// cycle while the response side is not stalled; a request passes the input
// register, then the decision logic and result register. The bitmaps are
// read, modified and written back at the same edge the result is registered,
// so a request always sees the effect of the one before it. Bitmaps come out
// of reset all free at once; no clearing pass is needed. Base registers may
// be written through the register channel only while no request is in
// flight; writes to indexes past the large pool are accepted and ignored.
module tiered_bitmap_slab_allocator_unit (
  input logic       clk_i,
  input logic       rst_ni,
  tbsa_req_if.sink   req_i,
  tbsa_rsp_if.source rsp_o,
  tbsa_cfg_if.sink   cfg_i
);
  import tbsa_pkg::*;

  logic   in_valid_q, in_valid_d;
  logic   out_valid_q, out_valid_d;
  req_t   req_q;
  rsp_t   rsp_q;
  bases_t bases_q;
  maps_t  used_q;
  maps_t  used_d;
  rsp_t   core_rsp;
  logic   advance;
  logic   accept;

  tbsa_core u_core (
    .req_i  (req_q),
    .bases_i(bases_q),
    .maps_i (used_q),
    .rsp_o  (core_rsp),
    .maps_o (used_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept)       in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      for (int t = 0; t < NUM_TIERS; t++) bases_q[t] <= BASE_RESET[t];
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) used_q <= used_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_BASE_TINY:   bases_q[0] <= cfg_i.data;
          REG_BASE_SMALL:  bases_q[1] <= cfg_i.data;
          REG_BASE_MEDIUM: bases_q[2] <= cfg_i.data;
          REG_BASE_LARGE:  bases_q[3] <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd          <= req_i.cmd;
      req_q.alloc_size   <= req_i.alloc_size;
      req_q.free_address <= req_i.free_address;
    end
    if (advance) rsp_q <= core_rsp;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = rsp_q.status;
  assign rsp_o.address    = rsp_q.address;
  assign rsp_o.tier       = rsp_q.tier;
  assign rsp_o.slot_index = rsp_q.slot_index;

  // A successful allocate takes exactly one slot
  a_alloc_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && core_rsp.status == ST_ALLOCATED) |=>
      ($countones(used_q) == $past($countones(used_q)) + 1))
    else $error("allocate did not take exactly one slot");

  // Failures leave every bitmap untouched
  a_fail_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (core_rsp.status == ST_FULL || core_rsp.status == ST_BAD_SIZE ||
                 core_rsp.status == ST_NOT_SLOT)) |=> $stable(used_q))
    else $error("failed request changed a bitmap");

  // Bits past a pool's slot count never get set
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used_q[0] & ~tier_mask(0)) == '0) && ((used_q[1] & ~tier_mask(1)) == '0) &&
    ((used_q[2] & ~tier_mask(2)) == '0) && ((used_q[3] & ~tier_mask(3)) == '0))
    else $error("bitmap bit set beyond slot count");

  // A held request is not overwritten
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(req_q)))
    else $error("pending request lost or overwritten");

  // Address is zero unless a slot was allocated
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rsp_q.status != ST_ALLOCATED) |-> (rsp_q.address == '0))
    else $error("nonzero address on a non-allocate response");

endmodule

/* verif/tbsa_checker.sv */
// Checker for the tiered bitmap slab allocator: mirrors the pool bitmaps and
// base registers, predicts each reply item and compares it as it arrives.
// Depends on tbsa_pkg and the channel interfaces in tbsa_if.
`timescale 1ns / 1ps

module tbsa_checker
  import tbsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tbsa_req_if         req_i,
  tbsa_rsp_if         rsp_i,
  tbsa_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned MAX_REPORTS = 10;

  logic [ADDR_W-1:0] pool_base [NUM_TIERS];
  map_t              pool_used [NUM_TIERS];
  rsp_t              pending_replies [$];

  // Applies one request to the mirrored pools and returns the reply it earns.
  function automatic rsp_t allocate_or_release(cmd_e cmd, logic [SIZE_W-1:0] size,
                                               logic [ADDR_W-1:0] addr);
    rsp_t              r;
    int                first_tier;
    bit                done;
    logic [63:0]       span;
    logic [ADDR_W-1:0] off;
    int unsigned       idx;
    r = '0;
    done = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (size == '0 || size > SIZE_LARGE) begin
        r.status = ST_BAD_SIZE;
      end else begin
        r.status = ST_FULL;
        if (size > SIZE_MEDIUM) first_tier = 3;
        else if (size > SIZE_SMALL) first_tier = 2;
        else if (size > SIZE_TINY) first_tier = 1;
        else first_tier = 0;
        // smallest fitting tier first, then fall back to larger ones
        for (int t = first_tier; t < NUM_TIERS; t++) begin
          for (int i = 0; i < int'(TIER_SLOTS[t]); i++) begin
            if (!done && !pool_used[t][i]) begin
              done = 1'b1;
              pool_used[t][i] = 1'b1;
              r.status = ST_ALLOCATED;
              r.address = pool_base[t] + (ADDR_W'(i) << TIER_SHIFT[t]);
              r.tier = tier_t'(t);
              r.slot_index = SLOT_W'(i);
            end
          end
        end
      end
    end else begin
      r.status = ST_NOT_SLOT;
      // first pool whose range holds the address decides, even if off a boundary
      for (int t = 0; t < NUM_TIERS; t++) begin
        if (!done) begin
          span = 64'(TIER_SLOTS[t]) << TIER_SHIFT[t];
          off = addr - pool_base[t];
          if (addr >= pool_base[t] && 64'(off) < span) begin
            done = 1'b1;
            if ((off & ((ADDR_W'(1) << TIER_SHIFT[t]) - 1)) == '0) begin
              idx = off >> TIER_SHIFT[t];
              pool_used[t][idx] = 1'b0;
              r.status = ST_FREED;
              r.tier = tier_t'(t);
              r.slot_index = SLOT_W'(idx);
            end
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TIERS; t++) begin
        pool_base[t] = BASE_RESET[t];
        pool_used[t] = '0;
      end
      pending_replies.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_replies.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("%0t: reply item with none expected: status %0d addr %h tier %0d slot %0d",
                     $realtime, rsp_i.status, rsp_i.address, rsp_i.tier, rsp_i.slot_index);
          fail_count_o++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp_i.status !== want.status || rsp_i.address !== want.address ||
              rsp_i.tier !== want.tier || rsp_i.slot_index !== want.slot_index) begin
            if (fail_count_o < MAX_REPORTS)
              $display({"%0t: reply mismatch: expected status %0d addr %h tier %0d slot %0d,",
                        " got status %0d addr %h tier %0d slot %0d"},
                       $realtime, want.status, want.address, want.tier, want.slot_index,
                       rsp_i.status, rsp_i.address, rsp_i.tier, rsp_i.slot_index);
            fail_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_BASE_TINY:   pool_base[0] = cfg_i.data;
          REG_BASE_SMALL:  pool_base[1] = cfg_i.data;
          REG_BASE_MEDIUM: pool_base[2] = cfg_i.data;
          REG_BASE_LARGE:  pool_base[3] = cfg_i.data;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready)
        pending_replies.push_back(allocate_or_release(req_i.cmd, req_i.alloc_size,
                                                      req_i.free_address));
      pending_o = pending_replies.size();
    end
  end

endmodule

/* verif/tb_tiered_bitmap_slab_allocator_unit.sv */
// Testbench top for the tiered bitmap slab allocator: clock, reset, request
// and register stimulus, reply backpressure, watchdog and verdict.
// Depends on tbsa_pkg, tbsa_if, the allocator RTL and tbsa_checker.
`timescale 1ns / 1ps

module tb_tiered_bitmap_slab_allocator_unit;
  import tbsa_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned LONG_HOLD       = 200;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'hFF;

  typedef enum int unsigned {
    BURST_FILL,
    BURST_RELEASE,
    BURST_MIXED,
    BURST_NOISE
  } burst_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  tbsa_req_if req_if ();
  tbsa_rsp_if rsp_if ();
  tbsa_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned stall_cycles;

  logic [ADDR_W-1:0] planned_base [NUM_TIERS];
  bit no_gaps;
  bit long_hold;

  tiered_bitmap_slab_allocator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  tbsa_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #4 clk_i = ~clk_i;

  // Ends the run when no item moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Reply side: random wait per item, plus an occasional long hold-off.
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        rsp_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      @(negedge clk_i);
    end
  end

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // valid only drops when a gap follows, so back-to-back items stay high
  task automatic send_item(cmd_e cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        = 1'b1;
    req_if.cmd          = cmd;
    req_if.alloc_size   = size;
    req_if.free_address = addr;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Writes all four bases plus one index past the large pool, block idle.
  task automatic program_bases(logic [ADDR_W-1:0] b0, logic [ADDR_W-1:0] b1,
                               logic [ADDR_W-1:0] b2, logic [ADDR_W-1:0] b3);
    logic [ADDR_W-1:0]    vals [NUM_TIERS+1];
    logic [CFG_IDX_W-1:0] idx  [NUM_TIERS+1];
    logic [CFG_IDX_W-1:0] spare;
    req_if.valid = 1'b0;
    wait_drained();
    spare = $urandom_range(0, 1) ? REG_SPARE_TOP : CFG_IDX_W'($urandom_range(NUM_TIERS, 254));
    vals = '{b0, b1, b2, b3, $urandom()};
    idx  = '{REG_BASE_TINY, REG_BASE_SMALL, REG_BASE_MEDIUM, REG_BASE_LARGE, spare};
    for (int i = 0; i <= NUM_TIERS; i++) begin
      cfg_if.valid = 1'b1;
      cfg_if.index = idx[i];
      cfg_if.data  = vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      @(negedge clk_i);
      if (i < NUM_TIERS) planned_base[i] = vals[i];
    end
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(int unsigned t);
    int unsigned lo;
    int unsigned hi;
    hi = 1 << TIER_SHIFT[t];
    if (t == 0) lo = 1;
    else lo = (1 << TIER_SHIFT[t-1]) + 1;
    case ($urandom_range(0, 9))
      0: return SIZE_W'(lo);
      1: return SIZE_W'(hi);
      default: return SIZE_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_bad_size();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return SIZE_W'(SIZE_LARGE + 1);
      2: return '1;
      default: return SIZE_W'($urandom_range(SIZE_LARGE + 1, 65535));
    endcase
  endfunction

  // Mostly slot boundaries of the programmed pools, then edges and noise.
  function automatic logic [ADDR_W-1:0] pick_free_address();
    int unsigned       t;
    int unsigned       kind;
    logic [ADDR_W-1:0] boundary;
    t = $urandom_range(0, NUM_TIERS - 1);
    boundary = planned_base[t] +
               (ADDR_W'($urandom_range(0, TIER_SLOTS[t] - 1)) << TIER_SHIFT[t]);
    kind = $urandom_range(0, 99);
    if (kind < 65) return boundary;
    if (kind < 80) return boundary + ADDR_W'($urandom_range(1, (1 << TIER_SHIFT[t]) - 1));
    if (kind < 85) return planned_base[t] - 1;
    if (kind < 90) return planned_base[t] + (ADDR_W'(TIER_SLOTS[t]) << TIER_SHIFT[t]);
    return $urandom();
  endfunction

  // Bursts of allocations or releases with random content, some mixed and noise.
  task automatic run_random(int unsigned count, int unsigned fill_pct);
    int unsigned left;
    int unsigned t;
    int unsigned slot;
    int unsigned roll;
    burst_e      kind;
    left = 0;
    t = 0;
    slot = 0;
    kind = BURST_FILL;
    for (int unsigned n = 0; n < count; n++) begin
      if (left == 0) begin
        left = $urandom_range(4, 20);
        t = $urandom_range(0, NUM_TIERS - 1);
        slot = $urandom_range(0, TIER_SLOTS[t] - 1);
        no_gaps = ($urandom_range(0, 4) == 0);
        roll = $urandom_range(0, 99);
        if (roll >= 92) kind = BURST_NOISE;
        else if (roll >= 80) kind = BURST_MIXED;
        else if ($urandom_range(0, 99) < fill_pct) kind = BURST_FILL;
        else kind = BURST_RELEASE;
      end
      left--;
      case (kind)
        BURST_FILL: begin
          if ($urandom_range(0, 9) == 0)
            send_item(CMD_ALLOC, pick_size($urandom_range(0, NUM_TIERS - 1)), $urandom());
          else
            send_item(CMD_ALLOC, pick_size(t), $urandom());
        end
        BURST_RELEASE: begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(CMD_FREE, SIZE_W'($urandom()),
                      planned_base[t] + (ADDR_W'(slot) << TIER_SHIFT[t]));
            slot = (slot + 1) % TIER_SLOTS[t];
          end else begin
            send_item(CMD_FREE, SIZE_W'($urandom()), pick_free_address());
          end
        end
        BURST_MIXED: begin
          if ($urandom_range(0, 1) == 0)
            send_item(CMD_ALLOC, pick_size($urandom_range(0, NUM_TIERS - 1)), $urandom());
          else
            send_item(CMD_FREE, SIZE_W'($urandom()), pick_free_address());
        end
        default: begin
          if ($urandom_range(0, 1) == 0)
            send_item(CMD_ALLOC, pick_bad_size(), $urandom());
          else
            send_item(CMD_FREE, SIZE_W'($urandom()), $urandom());
        end
      endcase
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_ALLOC;
    req_if.alloc_size   = '0;
    req_if.free_address = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    no_gaps             = 1'b0;
    long_hold           = 1'b0;
    for (int t = 0; t < NUM_TIERS; t++) planned_base[t] = BASE_RESET[t];
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed items at the reset bases
    send_item(CMD_ALLOC, '0, '1);
    send_item(CMD_ALLOC, '1, '0);
    send_item(CMD_ALLOC, SIZE_W'(SIZE_LARGE + 1), '0);
    send_item(CMD_ALLOC, 16'd1, '0);
    send_item(CMD_ALLOC, SIZE_TINY, '0);
    send_item(CMD_ALLOC, SIZE_W'(SIZE_TINY + 1), '0);
    send_item(CMD_ALLOC, SIZE_SMALL, '0);
    send_item(CMD_ALLOC, SIZE_W'(SIZE_SMALL + 1), '0);
    send_item(CMD_ALLOC, SIZE_MEDIUM, '0);
    send_item(CMD_ALLOC, SIZE_W'(SIZE_MEDIUM + 1), '0);
    send_item(CMD_ALLOC, SIZE_LARGE, '0);
    send_item(CMD_FREE, '0, planned_base[0]);
    send_item(CMD_FREE, '0, planned_base[0]);          // already free
    send_item(CMD_FREE, '1, planned_base[0] + 33);     // inside tiny, off a boundary
    send_item(CMD_FREE, '0, 32'd512);                  // between pools
    send_item(CMD_FREE, '0, '1);
    send_item(CMD_FREE, '0, planned_base[1] + SIZE_SMALL);
    send_item(CMD_FREE, '0, planned_base[3] + 15 * SIZE_LARGE);
    send_item(CMD_FREE, '0, planned_base[3] + 16 * SIZE_LARGE);
    send_item(CMD_FREE, '0, planned_base[2] + 1);
    run_random(ITEMS_PER_PHASE, 60);

    // All pools overlap at zero
    program_bases('0, '0, '0, '0);
    long_hold = 1'b1;
    run_random(ITEMS_PER_PHASE, 75);

    // Pools at the top of the address space; allocations wrap
    program_bases(32'hFFFF_FFE0, 32'hFFFF_FF80, 32'hFFFF_FE00, 32'hFFFF_F800);
    run_random(ITEMS_PER_PHASE, 50);

    program_bases(($urandom() >> TIER_SHIFT[0]) << TIER_SHIFT[0],
                  ($urandom() >> TIER_SHIFT[1]) << TIER_SHIFT[1],
                  ($urandom() >> TIER_SHIFT[2]) << TIER_SHIFT[2],
                  ($urandom() >> TIER_SHIFT[3]) << TIER_SHIFT[3]);
    long_hold = 1'b1;
    run_random(ITEMS_PER_PHASE, 40);

    // Unaligned bases, tiny pool at the very last address
    program_bases('1, $urandom(), $urandom(), $urandom());
    run_random(ITEMS_PER_PHASE, 50);

    req_if.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
